// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the sorted-insert priority queue.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT_IMP(lbl, ante, cons)
`define SPQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/spq_pkg.sv
// Package for the sorted-insert priority queue: field widths, codes and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LIST   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_LISTED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic insert;
        logic rotate;
    } dp_cmd_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [VALUE_W-1:0] head_value;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/spq_datapath.sv
// Datapath of the priority queue: a row of compare-and-shift cells and the fill count.
// Depends on spq_pkg.
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            dp_cmd,
    input  wire logic [VALUE_W-1:0] new_value,
    input  wire logic [PRIO_W-1:0]  new_priority,
    output dp_stat_t                dp_stat,
    output logic [CW-1:0]           count
);

    logic [VALUE_W-1:0] val_reg  [DEPTH];
    logic [VALUE_W-1:0] val_next [DEPTH];
    logic [PRIO_W-1:0]  pri_reg  [DEPTH];
    logic [PRIO_W-1:0]  pri_next [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [DEPTH-1:0]   ge;
    logic               full;

    assign full = (count_reg == CW'(DEPTH));

    // Stored entries are sorted, so the cells that hold a priority at least
    // as large as the new one form a prefix of the row.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = (CW'(i) < count_reg) && (pri_reg[i] >= new_priority);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            if (dp_cmd.insert)
            begin
                if (!ge[i])
                begin
                    if (i == 0 || ge[(i + DEPTH - 1) % DEPTH])
                    begin
                        val_next[i] = new_value;
                        pri_next[i] = new_priority;
                    end
                    else
                    begin
                        val_next[i] = val_reg[(i + DEPTH - 1) % DEPTH];
                        pri_next[i] = pri_reg[(i + DEPTH - 1) % DEPTH];
                    end
                end
            end
            else if (dp_cmd.rotate)
            begin
                // The occupied part of the row turns one place so that the
                // next entry comes to the head; the head wraps to the tail.
                if (CW'(i + 1) == count_reg)
                begin
                    val_next[i] = val_reg[0];
                    pri_next[i] = pri_reg[0];
                end
                else if (CW'(i + 1) < count_reg)
                begin
                    val_next[i] = val_reg[(i + 1) % DEPTH];
                    pri_next[i] = pri_reg[(i + 1) % DEPTH];
                end
            end
        end
        if (dp_cmd.insert && !full)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            val_reg[i] <= val_next[i];
            pri_reg[i] <= pri_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign dp_stat.full       = full;
    assign dp_stat.empty      = (count_reg == '0);
    assign dp_stat.head_value = val_reg[0];
    assign count              = count_reg;

endmodule

`default_nettype wire

// File: rtl/spq_ctrl.sv
// Controller of the priority queue: command decode, listing sequencer and
// the registered result port. Depends on spq_pkg.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      cmd,
    output logic                           busy,
    output dp_cmd_t                        dp_cmd,
    input  wire dp_stat_t                  dp_stat,
    input  wire logic [CW-1:0]             count,
    output logic                           result_strobe,
    output logic [1:0]                     status,
    output logic signed [VALUE_W-1:0]      entry_value,
    output logic                           last
);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      remain_reg, remain_next;
    logic               strobe_reg, strobe_next;
    logic [1:0]         status_reg, status_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg, last_next;
    logic               accept;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        remain_next   = remain_reg;
        strobe_next   = 1'b0;
        status_next   = status_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        dp_cmd.insert = 1'b0;
        dp_cmd.rotate = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    value_next  = '0;
                    if (cmd == CMD_INSERT)
                    begin
                        status_next   = dp_stat.full ? ST_FULL : ST_INSERTED;
                        dp_cmd.insert = !dp_stat.full;
                    end
                    else if (dp_stat.empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        status_next   = ST_LISTED;
                        value_next    = dp_stat.head_value;
                        dp_cmd.rotate = 1'b1;
                        last_next     = (count == CW'(1));
                        remain_next   = count - CW'(1);
                        if (count != CW'(1))
                        begin
                            state_next = S_LIST;
                        end
                    end
                end
            end
            S_LIST:
            begin
                strobe_next   = 1'b1;
                status_next   = ST_LISTED;
                value_next    = dp_stat.head_value;
                dp_cmd.rotate = 1'b1;
                last_next     = (remain_reg == CW'(1));
                remain_next   = remain_reg - CW'(1);
                if (remain_reg == CW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            remain_reg <= '0;
            strobe_reg <= 1'b0;
            status_reg <= ST_INSERTED;
            value_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
            strobe_reg <= strobe_next;
            status_reg <= status_next;
            value_reg  <= value_next;
            last_reg   <= last_next;
        end
    end

    assign busy          = (state_reg == S_LIST);
    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign entry_value   = $signed(value_reg);
    assign last          = last_reg;

endmodule

`default_nettype wire

// File: rtl/sorted_insert_priority_queue_top.sv
// Sorted-insert priority queue: an insert or an empty/full answer gives one result
// beat in the cycle after start is taken; a listing gives one beat per stored entry,
// the first in the cycle after start and holds busy high until its last beat is out.
// Inserts are taken every cycle while idle; the listing rate is set by the cell row
// turning one place per cycle. Reset empties the queue; results cannot be stalled.
`default_nettype none
`include "assert_macros.svh"

module sorted_insert_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      cmd,
    input  wire logic signed [VALUE_W-1:0] item_value,
    input  wire logic [PRIO_W-1:0]         item_priority,
    output logic                           result_strobe,
    output logic [1:0]                     status,
    output logic signed [VALUE_W-1:0]      entry_value,
    output logic                           last
);

    localparam int CW = $clog2(DEPTH + 1);

    dp_cmd_t       dp_cmd;
    dp_stat_t      dp_stat;
    logic [CW-1:0] count;

    spq_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .new_value   ($unsigned(item_value)),
        .new_priority(item_priority),
        .dp_stat     (dp_stat),
        .count       (count)
    );

    spq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .count        (count),
        .result_strobe(result_strobe),
        .status       (status),
        .entry_value  (entry_value),
        .last         (last)
    );

    // Every accepted command answers in the next cycle.
    `SPQ_ASSERT_NXT(a_accept_answers, start && !busy, result_strobe)
    // A listing in progress puts out a beat every cycle.
    `SPQ_ASSERT_IMP(a_busy_streams, busy, result_strobe)
    // A listed beat that is not the last keeps the listing going.
    `SPQ_ASSERT_IMP(a_list_continues, result_strobe && status == ST_LISTED && !last, busy)
    // Every result other than a listed entry is a single closing beat with no value.
    `SPQ_ASSERT_IMP(a_single_beat, result_strobe && status != ST_LISTED,
                    last && entry_value == '0)

endmodule

`default_nettype wire
